@@ src/tmw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tmw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CCNT_W  = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);

    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int COL_W   = 7;
    localparam int LINE_W  = 5;
    localparam int CELL_W  = CHAR_W + ATTR_W;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] RESET_COLOUR = 8'd8;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR
    } state_t;

endpackage

`default_nettype wire

@@ src/tmw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tmw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ src/text_mode_terminal_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Text-mode screen store of COLUMNS x ROWS cells (character byte low, attribute
// byte high) with a cursor, held in one single-port-write RAM with a registered
// read. Rows are kept as a ring: a scroll moves the top-row pointer and clears
// the recycled row, so no cells are copied. Put-character, direct write,
// out-of-range read and unused-mode results are registered on acceptance;
// an in-range read first passes the READ state (registered RAM read) and a
// put that scrolls the CLEAR state (row clear through the RAM write port).
// After reset a clearing pass writes every cell once and no transaction is
// accepted until it ends; the colour register may be written during it. A
// finished result sits in an output register; while it is stalled no new
// transaction is taken, and the next one is taken in the cycle it leaves.
module text_mode_terminal_writer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_wr_en,
    input  wire logic [tmw_pkg::ATTR_W-1:0]  cfg_wr_data,

    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [tmw_pkg::MODE_W-1:0]  mode,
    input  wire logic [tmw_pkg::CHAR_W-1:0]  char_code,
    input  wire logic [tmw_pkg::ATTR_W-1:0]  cell_colour,
    input  wire logic [tmw_pkg::COL_W-1:0]   col,
    input  wire logic [tmw_pkg::LINE_W-1:0]  line,

    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [tmw_pkg::CHAR_W-1:0]  cell_char,
    output logic      [tmw_pkg::ATTR_W-1:0]  cell_attr,
    output logic      [tmw_pkg::LINE_W-1:0]  cursor_line,
    output logic      [tmw_pkg::COL_W-1:0]   cursor_col
);

    import tmw_pkg::*;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   init_cnt_reg, init_cnt_next;
    logic [CCNT_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ROW_W-1:0]    base_reg, base_next;
    logic [LINE_W-1:0]   cur_row_reg, cur_row_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ATTR_W-1:0]   colour_reg;

    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   cell_char_reg, cell_char_next;
    logic [ATTR_W-1:0]   cell_attr_reg, cell_attr_next;
    logic [LINE_W-1:0]   cursor_line_reg, cursor_line_next;
    logic [COL_W-1:0]    cursor_col_reg, cursor_col_next;

    logic                accept;
    logic                in_range;
    logic                is_newline;
    logic                wrap;
    logic                bottom;
    logic                scroll;
    logic [COL_W:0]      col_inc;
    logic                out_load;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    // logical row -> physical address, rows rotated by the ring pointer
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [LINE_W-1:0] r,
        input logic [COL_W-1:0]  c,
        input logic [ROW_W-1:0]  base
    );
        logic [LINE_W:0] prow;
        prow = {1'b0, r} + (LINE_W + 1)'(base);
        if (prow >= (LINE_W + 1)'(ROWS))
        begin
            prow = prow - (LINE_W + 1)'(ROWS);
        end
        return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

    tmw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    assign in_range   = (col < COL_W'(COLUMNS)) && (line < LINE_W'(ROWS));
    assign is_newline = (char_code == NEWLINE_CODE);
    assign col_inc    = {1'b0, cur_col_reg} + 1'b1;
    assign wrap       = is_newline || (col_inc >= (COL_W + 1)'(COLUMNS));
    assign bottom     = (cur_row_reg == LINE_W'(ROWS - 1));
    assign scroll     = (mode == MODE_PUT) && wrap && bottom;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (init_cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_READ && in_range)
                    begin
                        state_next = ST_READ;
                    end
                    else if (scroll)
                    begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CCNT_W'(COLUMNS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        init_cnt_next    = init_cnt_reg;
        clr_cnt_next     = clr_cnt_reg;
        base_next        = base_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        ram_we           = 1'b0;
        ram_waddr        = cell_addr(cur_row_reg, cur_col_reg, base_reg);
        ram_wdata        = {colour_reg, char_code};
        ram_raddr        = cell_addr(line, col, base_reg);
        out_load         = 1'b0;
        cell_char_next   = '0;
        cell_attr_next   = '0;
        cursor_line_next = cur_row_reg;
        cursor_col_next  = cur_col_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we        = 1'b1;
                ram_waddr     = init_cnt_reg;
                ram_wdata     = {RESET_COLOUR, SPACE_CODE};
                init_cnt_next = init_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_PUT:
                        begin
                            ram_we = !is_newline;
                            if (wrap)
                            begin
                                cur_col_next = '0;
                                if (!bottom)
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = col_inc[COL_W-1:0];
                            end
                            out_load = !scroll;
                        end
                        MODE_WRITE:
                        begin
                            ram_we    = in_range;
                            ram_waddr = cell_addr(line, col, base_reg);
                            ram_wdata = {cell_colour, char_code};
                            out_load  = 1'b1;
                        end
                        MODE_READ:
                        begin
                            out_load = !in_range;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                    clr_cnt_next     = '0;
                    cursor_line_next = cur_row_next;
                    cursor_col_next  = cur_col_next;
                end
            end
            ST_READ:
            begin
                out_load       = 1'b1;
                cell_char_next = ram_rdata[CHAR_W-1:0];
                cell_attr_next = ram_rdata[CELL_W-1:CHAR_W];
            end
            ST_CLEAR:
            begin
                // the old top row becomes the new bottom row
                ram_we       = 1'b1;
                ram_waddr    = cell_addr('0, COL_W'(clr_cnt_reg), base_reg);
                ram_wdata    = {colour_reg, SPACE_CODE};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CCNT_W'(COLUMNS - 1))
                begin
                    out_load  = 1'b1;
                    base_next = (base_reg == ROW_W'(ROWS - 1)) ? '0 : base_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            clr_cnt_reg   <= '0;
            base_reg      <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            colour_reg    <= RESET_COLOUR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            base_reg      <= base_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                colour_reg <= cfg_wr_data;
            end
        end
    end

    // result payload; cursor captured at accept, cell data at completion
    always_ff @(posedge clk)
    begin
        if (accept || out_load)
        begin
            cursor_line_reg <= cursor_line_next;
            cursor_col_reg  <= cursor_col_next;
        end
        if (out_load)
        begin
            cell_char_reg <= cell_char_next;
            cell_attr_reg <= cell_attr_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_char   = cell_char_reg;
    assign cell_attr   = cell_attr_reg;
    assign cursor_line = cursor_line_reg;
    assign cursor_col  = cursor_col_reg;

endmodule

`default_nettype wire

@@ dv/tb_text_mode_terminal_writer.sv @@
`timescale 1ns / 1ps

module tb_text_mode_terminal_writer;

    import tmw_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = COLUMNS + 8;
    localparam int COL_MAX        = (1 << COL_W) - 1;
    localparam int LINE_MAX       = (1 << LINE_W) - 1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] chr;
        logic [ATTR_W-1:0] colour;
        logic [COL_W-1:0]  x;
        logic [LINE_W-1:0] y;
    } term_cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        logic [ATTR_W-1:0] attr;
        logic [LINE_W-1:0] row;
        logic [COL_W-1:0]  col;
    } term_reply_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [ATTR_W-1:0] cfg_wr_data = '0;
    logic              in_valid    = 1'b0;
    logic [MODE_W-1:0] mode        = '0;
    logic [CHAR_W-1:0] char_code   = '0;
    logic [ATTR_W-1:0] cell_colour = '0;
    logic [COL_W-1:0]  col         = '0;
    logic [LINE_W-1:0] line        = '0;
    logic              out_stall   = 1'b0;

    wire               in_stall;
    wire               out_valid;
    wire  [CHAR_W-1:0] cell_char;
    wire  [ATTR_W-1:0] cell_attr;
    wire  [LINE_W-1:0] cursor_line;
    wire  [COL_W-1:0]  cursor_col;

    // screen image and cursor as the block should hold them
    logic [CELL_W-1:0] screen_image [CELLS];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [ATTR_W-1:0] draw_colour;
    term_reply_t       terminal_replies [$];

    int errors       = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    int stall_left   = 0;
    bit idling_on    = 1'b1;
    bit hold_request = 1'b0;

    text_mode_terminal_writer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .char_code   (char_code),
        .cell_colour (cell_colour),
        .col         (col),
        .line        (line),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_char   (cell_char),
        .cell_attr   (cell_attr),
        .cursor_line (cursor_line),
        .cursor_col  (cursor_col)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_screen_image();
        for (int i = 0; i < CELLS; i++)
        begin
            screen_image[i] = {RESET_COLOUR, SPACE_CODE};
        end
        cur_row     = 0;
        cur_col     = 0;
        draw_colour = RESET_COLOUR;
    endfunction

    function automatic void take_new_line();
        cur_col = 0;
        if (cur_row < ROWS - 1)
        begin
            cur_row++;
        end
        else
        begin
            // scroll up a row, bottom row cleared in the current draw colour
            for (int i = 0; i < CELLS - COLUMNS; i++)
            begin
                screen_image[i] = screen_image[i + COLUMNS];
            end
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
            begin
                screen_image[i] = {draw_colour, SPACE_CODE};
            end
        end
    endfunction

    function automatic term_reply_t emulate_terminal(input term_cmd_t c);
        term_reply_t r;
        bit          in_range;
        int          addr;
        r        = '0;
        in_range = (c.x < COLUMNS) && (c.y < ROWS);
        addr     = c.y * COLUMNS + c.x;
        case (c.mode)
            MODE_PUT:
            begin
                if (c.chr == NEWLINE_CODE)
                begin
                    take_new_line();
                end
                else
                begin
                    screen_image[cur_row * COLUMNS + cur_col] = {draw_colour, c.chr};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                    begin
                        take_new_line();
                    end
                end
            end
            MODE_WRITE:
            begin
                if (in_range)
                begin
                    screen_image[addr] = {c.colour, c.chr};
                end
            end
            MODE_READ:
            begin
                if (in_range)
                begin
                    r.chr  = screen_image[addr][CHAR_W-1:0];
                    r.attr = screen_image[addr][CELL_W-1:CHAR_W];
                end
            end
            default:
            begin
            end
        endcase
        r.row = cur_row[LINE_W-1:0];
        r.col = cur_col[COL_W-1:0];
        return r;
    endfunction

    // one transaction on the input channel; valid is left high on return
    task automatic send_cmd(input term_cmd_t c);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= c.mode;
        char_code   <= c.chr;
        cell_colour <= c.colour;
        col         <= c.x;
        line        <= c.y;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        terminal_replies.push_back(emulate_terminal(c));
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        term_cmd_t c;
        c      = term_cmd_t'(30'($urandom));
        c.mode = MODE_PUT;
        c.chr  = ch;
        send_cmd(c);
    endtask

    task automatic write_cell(input int x, input int y, input logic [CHAR_W-1:0] ch,
                              input logic [ATTR_W-1:0] colour);
        term_cmd_t c;
        c = '{MODE_WRITE, ch, colour, x[COL_W-1:0], y[LINE_W-1:0]};
        send_cmd(c);
    endtask

    task automatic read_cell(input int x, input int y);
        term_cmd_t c;
        c        = term_cmd_t'(30'($urandom));
        c.mode   = MODE_READ;
        c.x      = x[COL_W-1:0];
        c.y      = y[LINE_W-1:0];
        send_cmd(c);
    endtask

    // colour register is only touched with the block drained
    task automatic set_draw_colour(input logic [ATTR_W-1:0] value);
        in_valid <= 1'b0;
        while (terminal_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        draw_colour = value;
    endtask

    // mostly the cursor row and the bottom row, where scrolls show up
    task automatic pick_cell(output int x, output int y);
        case ($urandom_range(0, 2))
            0:       y = cur_row;
            1:       y = ROWS - 1;
            default: y = $urandom_range(0, ROWS - 1);
        endcase
        x = $urandom_range(0, COLUMNS - 1);
        if ($urandom_range(0, 9) == 0)
        begin
            x = $urandom_range(COLUMNS, COL_MAX);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            y = $urandom_range(ROWS, LINE_MAX);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%02h actual 0x%02h", $time, name, want, got);
        end
    endtask

    // output side: checks each transaction and decides the stall for the next cycle
    always @(posedge clk)
    begin
        term_reply_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (terminal_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none actual %02h %02h %0d %0d",
                         $time, cell_char, cell_attr, cursor_line, cursor_col);
            end
            else
            begin
                want = terminal_replies.pop_front();
                check_field("cell_char", want.chr, cell_char);
                check_field("cell_attr", want.attr, cell_attr);
                check_field("cursor_line", 8'(want.row), 8'(cursor_line));
                check_field("cursor_col", 8'(want.col), 8'(cursor_col));
            end
        end
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 4);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_text_mode_terminal_writer failed");
            $finish;
        end
    end

    task automatic test_reset_state();
        read_cell(0, 0);
        read_cell(COLUMNS - 1, ROWS - 1);
        read_cell(COLUMNS, ROWS - 1);
        read_cell(0, ROWS);
        read_cell(COL_MAX, LINE_MAX);
        send_cmd('{MODE_UNUSED, 8'hFF, 8'hFF, 7'h7F, 5'h1F});
    endtask

    task automatic test_direct_write();
        write_cell(0, 0, 8'h00, 8'hFF);
        write_cell(COLUMNS - 1, ROWS - 1, 8'hFF, 8'h00);
        // out of range: must not alias onto the next row or anywhere else
        write_cell(COLUMNS, 5, 8'h41, 8'h1E);
        write_cell(5, LINE_MAX, 8'h42, 8'h2D);
        write_cell(0, ROWS, 8'h43, 8'h3C);
        read_cell(0, 0);
        read_cell(COLUMNS - 1, ROWS - 1);
        read_cell(0, 6);
    endtask

    task automatic test_put_character();
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(NEWLINE_CODE);
        put_char(8'h7E);
        read_cell(0, 0);
        read_cell(1, 0);
        read_cell(3, 0);
        read_cell(0, 1);
    endtask

    task automatic test_scroll();
        set_draw_colour(8'($urandom));
        write_cell(7, 1, 8'h5A, 8'hC3);
        while (cur_row < ROWS - 1) put_char(NEWLINE_CODE);
        put_char(8'h61);
        put_char(NEWLINE_CODE);
        read_cell(0, ROWS - 2);
        read_cell(7, 0);
        read_cell(0, ROWS - 1);
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 3 == 2)
            begin
                read_cell($urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1));
            end
            else
            begin
                put_char(8'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic(input logic [ATTR_W-1:0] colour, input int n_items);
        int        sent;
        int        run;
        int        x;
        int        y;
        term_cmd_t c;
        set_draw_colour(colour);
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // text run, long enough at times to wrap a whole row
                    run = $urandom_range(1, 100);
                    for (int k = 0; k < run && sent < n_items; k++)
                    begin
                        if ($urandom_range(0, 19) == 0)
                        begin
                            put_char(NEWLINE_CODE);
                        end
                        else
                        begin
                            put_char(8'($urandom));
                        end
                        sent++;
                    end
                end
                4, 5:
                begin
                    pick_cell(x, y);
                    write_cell(x, y, 8'($urandom), 8'($urandom));
                    read_cell(x, y);
                    sent += 2;
                end
                6, 7:
                begin
                    pick_cell(x, y);
                    read_cell(x, y);
                    sent++;
                end
                8:
                begin
                    run = $urandom_range(1, 5);
                    for (int k = 0; k < run; k++)
                    begin
                        put_char(NEWLINE_CODE);
                    end
                    sent += run;
                end
                default:
                begin
                    c = term_cmd_t'(30'($urandom));
                    send_cmd(c);
                    sent++;
                end
            endcase
        end
    endtask

    initial
    begin
        clear_screen_image();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_direct_write();
        test_put_character();
        test_scroll();
        test_backpressure();
        test_random_traffic(8'hFF, 120);
        test_random_traffic(8'h00, 120);
        test_random_traffic(8'($urandom), 120);
        idling_on = 1'b0;
        test_random_traffic(8'($urandom), 120);

        in_valid <= 1'b0;
        while (terminal_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_text_mode_terminal_writer passed");
        end
        else
        begin
            $display("tb_text_mode_terminal_writer failed");
        end
        $finish;
    end

endmodule
